@@ sv/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// scs_pkg
// Shared sizes, action codes and controller/datapath interface types for the
// shortest common supersequence length and count block.
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam int MAX_LEN = 32;

   localparam int SYM_W     = 8;
   localparam int ACT_W     = 2;
   localparam int SCS_LEN_W = 7;
   localparam int CNT_W     = 61;

   // string length / prefix index, holds 0..MAX_LEN
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int STR_AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int ROW_DEP = MAX_LEN + 1;
   localparam int ROW_AW  = $clog2(ROW_DEP);
   localparam int ROW_W   = SCS_LEN_W + CNT_W;

   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_LEN);

   localparam logic [ACT_W-1:0] ACT_APPEND_A = 2'd0;
   localparam logic [ACT_W-1:0] ACT_APPEND_B = 2'd1;
   localparam logic [ACT_W-1:0] ACT_COMPUTE  = 2'd2;

   typedef struct packed {
      logic append_a;    // store symbol into first string
      logic append_b;    // store symbol into second string
      logic trivial;     // one string empty, result known directly
      logic init_begin;  // start of table walk
      logic init_write;  // seed row entry j
      logic row_setup;   // start of row i
      logic walk_step;   // evaluate cell (i, j)
      logic emit;        // move result into output register
   } cmd_type;

   typedef struct packed {
      logic n1_zero;
      logic n2_zero;
      logic i_last;
      logic j_last;
      logic out_free;
   } sts_type;

endpackage

@@ sv/scs_ram.sv @@
// ----------------------------------------------------------------------------
// scs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module scs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/scs_ctrl.sv @@
// ----------------------------------------------------------------------------
// scs_ctrl
// Sequencer: accepts words, seeds the rolling row, steps rows and cells of
// the prefix table, and hands the result to the output register.
// ----------------------------------------------------------------------------
module scs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [scs_pkg::ACT_W-1:0]  req_action,
   input  scs_pkg::sts_type           sts,
   output scs_pkg::cmd_type           cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_INIT = 3'd1;
   localparam logic [2:0] ST_ROW  = 3'd2;
   localparam logic [2:0] ST_CELL = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  scs_pkg::ACT_APPEND_A: cmd.append_a = 1'b1;
                  scs_pkg::ACT_APPEND_B: cmd.append_b = 1'b1;
                  scs_pkg::ACT_COMPUTE: begin
                     if (sts.n1_zero || sts.n2_zero) begin
                        cmd.trivial = 1'b1;
                        state_in    = ST_DONE;
                     end else begin
                        cmd.init_begin = 1'b1;
                        state_in       = ST_INIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            cmd.init_write = 1'b1;
            if (sts.j_last) begin
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            cmd.row_setup = 1'b1;
            state_in      = ST_CELL;
         end
         ST_CELL: begin
            cmd.walk_step = 1'b1;
            if (sts.j_last) begin
               state_in = sts.i_last ? ST_DONE : ST_ROW;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/scs_dp.sv @@
// ----------------------------------------------------------------------------
// scs_dp
// Datapath: string stores, rolling row store, cell evaluation, prefix
// counters and the output register.
// ----------------------------------------------------------------------------
module scs_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [scs_pkg::SYM_W-1:0]     req_symbol,
   input  scs_pkg::cmd_type              cmd,
   output scs_pkg::sts_type              sts,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [scs_pkg::SCS_LEN_W-1:0] rsp_scs_length,
   output logic [scs_pkg::CNT_W-1:0]     rsp_scs_count,
   output logic                          rsp_overflow
);

   localparam int LW = scs_pkg::SCS_LEN_W;
   localparam int CW = scs_pkg::CNT_W;
   localparam int NW = scs_pkg::LEN_W;

   logic [NW-1:0] len_a_ff, len_b_ff, i_ff, j_ff;
   logic          dropped_ff;
   logic [LW-1:0] left_len_ff, diag_len_ff, res_len_ff;
   logic [CW-1:0] left_cnt_ff, diag_cnt_ff, res_cnt_ff;
   logic          rsp_valid_ff, rsp_overflow_ff;
   logic [LW-1:0] rsp_len_ff;
   logic [CW-1:0] rsp_cnt_ff;

   logic                        wr_a, wr_b;
   logic [scs_pkg::SYM_W-1:0]   sym_a, sym_b;
   logic                        str_a_rd, str_b_rd, row_rd_en, row_wr;
   logic [scs_pkg::STR_AW-1:0]  a_rd_addr, b_rd_addr;
   logic [scs_pkg::ROW_AW-1:0]  row_rd_addr;
   logic [scs_pkg::ROW_W-1:0]   row_rd_data, row_wr_data;
   logic [NW-1:0]               i_minus, j_plus;

   logic [LW-1:0] up_len, min_len, new_len;
   logic [CW-1:0] up_cnt, new_cnt, pick_up, pick_left;
   logic          match;

   // ---------------- string stores ----------------
   assign wr_a = cmd.append_a && (len_a_ff != scs_pkg::LEN_FULL);
   assign wr_b = cmd.append_b && (len_b_ff != scs_pkg::LEN_FULL);

   assign i_minus   = i_ff - NW'(1);
   assign j_plus    = j_ff + NW'(1);
   assign a_rd_addr = i_minus[scs_pkg::STR_AW-1:0];
   assign b_rd_addr = cmd.row_setup ? '0 : j_ff[scs_pkg::STR_AW-1:0];

   // s1 symbol is read once per row and held by the RAM output register
   assign str_a_rd  = cmd.row_setup;
   assign str_b_rd  = cmd.row_setup || (cmd.walk_step && !sts.j_last);
   assign row_rd_en = str_b_rd;
   assign row_rd_addr = cmd.row_setup ? scs_pkg::ROW_AW'(1) : j_plus[scs_pkg::ROW_AW-1:0];

   scs_ram #(.WIDTH(scs_pkg::SYM_W), .DEPTH(scs_pkg::MAX_LEN)) u_str_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (len_a_ff[scs_pkg::STR_AW-1:0]),
      .wr_data (req_symbol),
      .rd_en   (str_a_rd),
      .rd_addr (a_rd_addr),
      .rd_data (sym_a)
   );

   scs_ram #(.WIDTH(scs_pkg::SYM_W), .DEPTH(scs_pkg::MAX_LEN)) u_str_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (len_b_ff[scs_pkg::STR_AW-1:0]),
      .wr_data (req_symbol),
      .rd_en   (str_b_rd),
      .rd_addr (b_rd_addr),
      .rd_data (sym_b)
   );

   // ---------------- rolling row ----------------
   // entry j holds {length, count} of prefix pair (i-1, j); entry 0 is never stored
   assign row_wr      = cmd.init_write || cmd.walk_step;
   assign row_wr_data = cmd.init_write ? {LW'(j_ff), CW'(1)} : {new_len, new_cnt};

   scs_ram #(.WIDTH(scs_pkg::ROW_W), .DEPTH(scs_pkg::ROW_DEP)) u_row (
      .clock   (clock),
      .wr_en   (row_wr),
      .wr_addr (j_ff[scs_pkg::ROW_AW-1:0]),
      .wr_data (row_wr_data),
      .rd_en   (row_rd_en),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   // ---------------- cell evaluation ----------------
   assign up_len  = row_rd_data[CW +: LW];
   assign up_cnt  = row_rd_data[CW-1:0];
   assign match   = (sym_a == sym_b);
   assign min_len = (up_len < left_len_ff) ? up_len : left_len_ff;

   assign pick_up   = (up_len == min_len) ? up_cnt : '0;
   assign pick_left = (left_len_ff == min_len) ? left_cnt_ff : '0;

   assign new_len = match ? (diag_len_ff + LW'(1)) : (min_len + LW'(1));
   assign new_cnt = match ? diag_cnt_ff : (pick_up + pick_left);

   // ---------------- status ----------------
   assign sts.n1_zero  = (len_a_ff == '0);
   assign sts.n2_zero  = (len_b_ff == '0);
   assign sts.i_last   = (i_ff == len_a_ff);
   assign sts.j_last   = (j_ff == len_b_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.append_a) begin
            if (wr_a) len_a_ff <= len_a_ff + NW'(1);
            else      dropped_ff <= 1'b1;
         end
         if (cmd.append_b) begin
            if (wr_b) len_b_ff <= len_b_ff + NW'(1);
            else      dropped_ff <= 1'b1;
         end
         if (cmd.emit) begin
            len_a_ff     <= '0;
            len_b_ff     <= '0;
            dropped_ff   <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- walk registers ----------------
   always_ff @(posedge clock) begin
      if (cmd.init_begin) begin
         i_ff <= NW'(1);
         j_ff <= NW'(1);
      end else if (cmd.init_write) begin
         j_ff <= j_plus;
      end else if (cmd.row_setup) begin
         j_ff        <= NW'(1);
         left_len_ff <= LW'(i_ff);
         left_cnt_ff <= CW'(1);
         diag_len_ff <= LW'(i_minus);
         diag_cnt_ff <= CW'(1);
      end else if (cmd.walk_step) begin
         j_ff        <= j_plus;
         left_len_ff <= new_len;
         left_cnt_ff <= new_cnt;
         diag_len_ff <= up_len;
         diag_cnt_ff <= up_cnt;
         res_len_ff  <= new_len;
         res_cnt_ff  <= new_cnt;
         if (sts.j_last) i_ff <= i_ff + NW'(1);
      end

      if (cmd.trivial) begin
         res_len_ff <= sts.n1_zero ? LW'(len_b_ff) : LW'(len_a_ff);
         res_cnt_ff <= CW'(1);
      end

      if (cmd.emit) begin
         rsp_len_ff      <= res_len_ff;
         rsp_cnt_ff      <= res_cnt_ff;
         rsp_overflow_ff <= dropped_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scs_length = rsp_len_ff;
   assign rsp_scs_count  = rsp_cnt_ff;
   assign rsp_overflow   = rsp_overflow_ff;

endmodule

@@ sv/scs_length_and_count.sv @@
// ----------------------------------------------------------------------------
// scs_length_and_count
// Loads two symbol strings and returns the shortest common supersequence
// length, the number of such supersequences and a symbol-drop flag.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------
//   req     | req_valid/req_ready  | req_action, req_symbol
//   rsp     | rsp_valid/rsp_ready  | rsp_scs_length, rsp_scs_count,
//           |                      | rsp_overflow
//
// A compute word with either string empty is answered directly from the
// other string's length; otherwise the rolling row store is seeded and
// then walked one cell per cycle.
// Synchronous active-high reset clears the string lengths and drop flag.
// req_ready is high only while idle; a finished result waits in the output
// register, and a following compute holds before its emit until it drains.
// ----------------------------------------------------------------------------
module scs_length_and_count (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [scs_pkg::ACT_W-1:0]     req_action,
   input  logic [scs_pkg::SYM_W-1:0]     req_symbol,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [scs_pkg::SCS_LEN_W-1:0] rsp_scs_length,
   output logic [scs_pkg::CNT_W-1:0]     rsp_scs_count,
   output logic                          rsp_overflow
);

   scs_pkg::cmd_type cmd;
   scs_pkg::sts_type sts;

   scs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .sts        (sts),
      .cmd        (cmd)
   );

   scs_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_symbol     (req_symbol),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scs_length (rsp_scs_length),
      .rsp_scs_count  (rsp_scs_count),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for scs_length_and_count. A directed table covers the
// empty, single-symbol, match, mismatch and unused-action cases. Random
// load/compute sequences follow, including full and overflowing stores.
// Every result word is checked against the expected value in its directed
// row or against an in-bench table walk. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [scs_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_WORDS   = 750;
   localparam int DIR_ROWS       = 23;

   typedef struct packed {
      logic [scs_pkg::SCS_LEN_W-1:0] len;
      logic [scs_pkg::CNT_W-1:0]     cnt;
      logic                          ovf;
   } result_type;

   typedef struct packed {
      logic [scs_pkg::ACT_W-1:0]     act;
      logic [scs_pkg::SYM_W-1:0]     sym;
      logic                          typed;  // expected result given in the row
      logic [scs_pkg::SCS_LEN_W-1:0] len;
      logic [scs_pkg::CNT_W-1:0]     cnt;
      logic                          ovf;
   } dir_row_type;

   typedef enum int {SYM_ANY, SYM_PAIR, SYM_DISJOINT} sym_mode_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [scs_pkg::ACT_W-1:0]     req_action = ACT_UNUSED;
   logic [scs_pkg::SYM_W-1:0]     req_symbol = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [scs_pkg::SCS_LEN_W-1:0] rsp_scs_length;
   logic [scs_pkg::CNT_W-1:0]     rsp_scs_count;
   logic                          rsp_overflow;

   // predictor state
   logic [scs_pkg::SYM_W-1:0] first_syms  [0:scs_pkg::MAX_LEN-1];
   logic [scs_pkg::SYM_W-1:0] second_syms [0:scs_pkg::MAX_LEN-1];
   int                        first_len  = 0;
   int                        second_len = 0;
   logic                      drop_seen  = 1'b0;

   result_type  pending_results [$];
   int          mismatches   = 0;
   int          sent_words   = 0;
   int          idle_cycles  = 0;
   bit          sender_calm  = 1'b0;

   dir_row_type directed_rows [0:DIR_ROWS-1] = '{
      '{scs_pkg::ACT_COMPUTE,  8'h00, 1'b1, 7'd0, 61'd1, 1'b0},  // both empty after reset
      '{ACT_UNUSED,            8'hFF, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_COMPUTE,  8'h5A, 1'b1, 7'd0, 61'd1, 1'b0},  // unused word left nothing
      '{scs_pkg::ACT_APPEND_A, 8'h00, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_COMPUTE,  8'h00, 1'b1, 7'd1, 61'd1, 1'b0},  // second string empty
      '{scs_pkg::ACT_APPEND_B, 8'hFF, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_COMPUTE,  8'hFF, 1'b1, 7'd1, 61'd1, 1'b0},  // first string empty
      '{scs_pkg::ACT_APPEND_A, 8'h41, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_APPEND_B, 8'h41, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_COMPUTE,  8'h00, 1'b1, 7'd1, 61'd1, 1'b0},  // single match
      '{scs_pkg::ACT_APPEND_A, 8'h01, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_APPEND_B, 8'h02, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_COMPUTE,  8'h00, 1'b1, 7'd2, 61'd2, 1'b0},  // single mismatch
      '{scs_pkg::ACT_APPEND_A, 8'hAA, 1'b0, 7'd0, 61'd0, 1'b0},
      '{ACT_UNUSED,            8'h55, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_APPEND_A, 8'h55, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_APPEND_B, 8'h55, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_APPEND_B, 8'hAA, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_COMPUTE,  8'h00, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_APPEND_A, 8'h80, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_APPEND_A, 8'h7F, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_APPEND_B, 8'h80, 1'b0, 7'd0, 61'd0, 1'b0},
      '{scs_pkg::ACT_COMPUTE,  8'h00, 1'b0, 7'd0, 61'd0, 1'b0}
   };

   scs_length_and_count DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_symbol     (req_symbol),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scs_length (rsp_scs_length),
      .rsp_scs_count  (rsp_scs_count),
      .rsp_overflow   (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // rolling-row walk of the prefix table over the loaded strings
   function automatic result_type walk_supersequence();
      logic [scs_pkg::SCS_LEN_W-1:0] len_row [0:scs_pkg::MAX_LEN];
      logic [scs_pkg::CNT_W-1:0]     cnt_row [0:scs_pkg::MAX_LEN];
      logic [scs_pkg::SCS_LEN_W-1:0] diag_len, up_len, left_len, least;
      logic [scs_pkg::CNT_W-1:0]     diag_cnt, up_cnt, left_cnt, sum;
      result_type                    r;
      for (int j = 0; j <= second_len; j++) begin
         len_row[j] = scs_pkg::SCS_LEN_W'(j);
         cnt_row[j] = scs_pkg::CNT_W'(1);
      end
      for (int i = 1; i <= first_len; i++) begin
         diag_len   = len_row[0];
         diag_cnt   = cnt_row[0];
         len_row[0] = scs_pkg::SCS_LEN_W'(i);
         cnt_row[0] = scs_pkg::CNT_W'(1);
         for (int j = 1; j <= second_len; j++) begin
            up_len   = len_row[j];
            up_cnt   = cnt_row[j];
            left_len = len_row[j-1];
            left_cnt = cnt_row[j-1];
            if (first_syms[i-1] == second_syms[j-1]) begin
               len_row[j] = diag_len + 1'b1;
               cnt_row[j] = diag_cnt;
            end else begin
               least = (up_len < left_len) ? up_len : left_len;
               sum   = '0;
               if (up_len == least) sum += up_cnt;
               if (left_len == least) sum += left_cnt;
               len_row[j] = least + 1'b1;
               cnt_row[j] = sum;
            end
            diag_len = up_len;
            diag_cnt = up_cnt;
         end
      end
      r.len = len_row[second_len];
      r.cnt = cnt_row[second_len];
      r.ovf = drop_seen;
      return r;
   endfunction

   // update predictor state for one accepted word
   function automatic void absorb_word(input logic [scs_pkg::ACT_W-1:0] act,
                                       input logic [scs_pkg::SYM_W-1:0] sym,
                                       input logic typed, input result_type typed_res);
      result_type r;
      case (act)
         scs_pkg::ACT_APPEND_A: begin
            if (first_len >= scs_pkg::MAX_LEN) drop_seen = 1'b1;
            else begin
               first_syms[first_len] = sym;
               first_len++;
            end
         end
         scs_pkg::ACT_APPEND_B: begin
            if (second_len >= scs_pkg::MAX_LEN) drop_seen = 1'b1;
            else begin
               second_syms[second_len] = sym;
               second_len++;
            end
         end
         scs_pkg::ACT_COMPUTE: begin
            r = typed ? typed_res : walk_supersequence();
            pending_results.push_back(r);
            first_len  = 0;
            second_len = 0;
            drop_seen  = 1'b0;
         end
         default: ;
      endcase
   endfunction

   function automatic int idle_gap(input bit calm);
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [scs_pkg::SYM_W-1:0] pick_symbol(
         input sym_mode_type mode, input bit second,
         input logic [scs_pkg::SYM_W-1:0] pair_a);
      case (mode)
         SYM_PAIR:     return $urandom_range(0, 1) ? pair_a : ~pair_a;
         SYM_DISJOINT: return {7'($urandom_range(0, 127)), second};
         default:      return scs_pkg::SYM_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_word(input logic [scs_pkg::ACT_W-1:0] act,
                            input logic [scs_pkg::SYM_W-1:0] sym,
                            input logic typed = 1'b0, input result_type typed_res = '0);
      int gap;
      gap = idle_gap(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_symbol <= sym;
      do @(posedge clock); while (!req_ready);
      absorb_word(act, sym, typed, typed_res);
      if (act != ACT_UNUSED) sent_words++;
   endtask

   // one load/compute sequence, or a short burst of noise
   task automatic run_sequence(input bit extreme);
      logic [scs_pkg::SYM_W-1:0] a_q [$];
      logic [scs_pkg::SYM_W-1:0] b_q [$];
      logic [scs_pkg::SYM_W-1:0] pair_a;
      sym_mode_type              mode;
      int                        la, lb, pick;
      pick        = $urandom_range(0, 99);
      mode        = sym_mode_type'($urandom_range(0, 2));
      pair_a      = scs_pkg::SYM_W'($urandom_range(0, 255));
      sender_calm = ($urandom_range(0, 4) == 0);
      if (extreme) begin
         // both stores full with no matches: longest walk and largest count
         la   = scs_pkg::MAX_LEN + 1;
         lb   = scs_pkg::MAX_LEN + 2;
         mode = SYM_DISJOINT;
      end else if (pick < 65) begin
         la = $urandom_range(0, 8);
         lb = $urandom_range(0, 8);
      end else if (pick < 82) begin
         la = $urandom_range(0, 20);
         lb = $urandom_range(9, 20);
      end else if (pick < 90) begin
         la = $urandom_range(20, scs_pkg::MAX_LEN);
         lb = $urandom_range(20, scs_pkg::MAX_LEN);
      end else if (pick < 95) begin
         la = $urandom_range(scs_pkg::MAX_LEN - 2, scs_pkg::MAX_LEN + 4);
         lb = $urandom_range(0, scs_pkg::MAX_LEN + 3);
      end else begin
         repeat ($urandom_range(1, 6))
            send_word(scs_pkg::ACT_W'($urandom_range(0, 3)),
                      scs_pkg::SYM_W'($urandom_range(0, 255)));
         return;
      end
      for (int k = 0; k < la; k++) a_q.push_back(pick_symbol(mode, 1'b0, pair_a));
      for (int k = 0; k < lb; k++) b_q.push_back(pick_symbol(mode, 1'b1, pair_a));
      while (a_q.size() + b_q.size() > 0) begin
         if ($urandom_range(0, 19) == 0)
            send_word(ACT_UNUSED, scs_pkg::SYM_W'($urandom_range(0, 255)));
         if (b_q.size() == 0 || (a_q.size() != 0 && $urandom_range(0, 1) == 1))
            send_word(scs_pkg::ACT_APPEND_A, a_q.pop_front());
         else
            send_word(scs_pkg::ACT_APPEND_B, b_q.pop_front());
      end
      send_word(scs_pkg::ACT_COMPUTE, scs_pkg::SYM_W'($urandom_range(0, 255)));
   endtask

   task automatic note_mismatch();
      mismatches++;
   endtask

   initial begin : stimulus
      result_type typed_res;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[k]) begin
         typed_res = '{directed_rows[k].len, directed_rows[k].cnt, directed_rows[k].ovf};
         send_word(directed_rows[k].act, directed_rows[k].sym, directed_rows[k].typed,
                   typed_res);
      end
      run_sequence(1'b1);
      while (sent_words < RANDOM_WORDS)
         run_sequence(1'b0);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("scs_length_and_count regression: pass");
      else
         $display("scs_length_and_count regression: fail");
      $finish;
   end

   // result side: ready runs of random length, with random stalls between
   initial begin : rsp_side
      int run, stall;
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = idle_gap(1'b0);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: result word with nothing expected: len %0d count %0d ovf %0b",
                        $realtime, rsp_scs_length, rsp_scs_count, rsp_overflow);
            note_mismatch();
         end else begin
            want = pending_results.pop_front();
            if (want.len != rsp_scs_length || want.cnt != rsp_scs_count
                || want.ovf != rsp_overflow) begin
               if (mismatches < 10)
                  $display("%0t: mismatch exp len %0d count %0d ovf %0b, %s %0d %0d %0b",
                           $realtime, want.len, want.cnt, want.ovf, "got len/count/ovf",
                           rsp_scs_length, rsp_scs_count, rsp_overflow);
               note_mismatch();
            end
         end
      end
   end

   // watchdog: cycles without any word moving on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("scs_length_and_count regression: fail");
         $finish;
      end
   end

endmodule
